FILE: rtl/core/i2cmra_pkg.sv
// Shared types and constants for the i2c register access master.
// No dependencies; imported by i2c_master_register_access.
package i2cmra_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int REQ_DATA_WIDTH      = 40;
   localparam int RSP_DATA_WIDTH      = 16;

   localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd1;
   localparam logic [CFG_WIDTH-1:0] ACK_TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_HALF_PERIOD = 1'b0,
      CSR_ACK_TIMEOUT = 1'b1
   } csr_index_type;

   // which byte of the transaction is on the wire
   typedef enum logic [1:0] {
      STG_DEVICE   = 2'd0,
      STG_REGISTER = 2'd1,
      STG_READ     = 2'd2,
      STG_DATA     = 2'd3
   } stage_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_WR_SETUP, PH_WR_HIGH,
      PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_RD_LOW, PH_RD_HIGH,
      PH_MACK_SET, PH_MACK_HIGH, PH_MACK_LOW, PH_STOP_A, PH_STOP_B, PH_FINISH
   } phase_type;

endpackage

FILE: rtl/core/i2c_master_register_access.sv
// I2C master for single register writes and burst register reads.
// Depends on i2cmra_pkg.
//
// Each word on the request stream is a command (write or read), a tick, or an unused opcode.
// A command taken while idle latches its operands; ticks then drive the SCL/SDA
// waveform one step at a time, each held step lasting half_period ticks (at least one), and
// every acknowledge is polled once per tick for up to ack_timeout_ticks ticks
// before the master sends stop and reports an error. Every request word gives
// exactly one response word carrying the line levels and the read/done flags.
// The block takes one word per clock: the sequencer update is a single pass of
// logic into its state registers, and a response register decouples the output,
// so the request side stalls only while a response waits to be taken.
module i2c_master_register_access
   import i2cmra_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // tdata: target_addr[7:0], reg_offset[15:8], write_data[23:16], read_count[31:24],
   //        sda_in[32], zero fill [39:33]
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [1:0]                req_tuser,   // opcode[1:0]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // tdata: scl[0], sda_out[1], busy_res[2], rd_data[10:3], rd_valid[11],
   //        done_res[12], status[13], zero fill [15:14]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tlast,   // rd_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_we,
   input  logic                      csr_addr,
   input  logic [CFG_WIDTH-1:0]      csr_wdata
);

   localparam logic [31:0] TMAX32 = (TIMER_WIDTH >= 32) ? 32'hffff_ffff :
                                    ((32'd1 << TIMER_WIDTH) - 32'd1);

   // saturate a 16 bit register value into the timer width
   function automatic logic [TIMER_WIDTH-1:0] sat_timer(input logic [CFG_WIDTH-1:0] v);
      logic [31:0] ext;
      ext = {{(32-CFG_WIDTH){1'b0}}, v};
      return (ext > TMAX32) ? TMAX32[TIMER_WIDTH-1:0] : ext[TIMER_WIDTH-1:0];
   endfunction

   // configuration
   logic [CFG_WIDTH-1:0]   half_period_ff, ack_timeout_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   stage_type              stage_ff, stage_in;
   logic [3:0]             bit_index_ff, bit_index_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic [7:0]             bytes_left_ff, bytes_left_in;
   logic [TIMER_WIDTH-1:0] delay_timer_ff, delay_timer_in;
   logic [TIMER_WIDTH-1:0] ack_timer_ff, ack_timer_in;
   logic [7:0]             held_device_ff, held_device_in;
   logic [7:0]             held_register_ff, held_register_in;
   logic [7:0]             held_write_byte_ff, held_write_byte_in;
   logic                   is_read_ff, is_read_in;
   logic                   failed_ff, failed_in;
   logic                   scl_ff, scl_in;
   logic                   sda_drive_ff, sda_drive_in;

   // response register
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_valid_ff;

   // request fields
   opcode_type             op;
   logic [7:0]             f_dev, f_reg, f_wdata, f_count;
   logic                   f_sda;
   logic                   accept;

   // per-word outputs
   logic [7:0]             rd_data;
   logic                   rd_valid, rd_last, done, status, hold;
   logic [CFG_WIDTH-1:0]   half_m1, ack_load;
   logic [3:0]             bit_next;

   assign op      = opcode_type'(req_tuser);
   assign f_dev   = req_tdata[7:0];
   assign f_reg   = req_tdata[15:8];
   assign f_wdata = req_tdata[23:16];
   assign f_count = req_tdata[31:24];
   assign f_sda   = req_tdata[32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign half_m1  = (half_period_ff == '0) ? '0 : half_period_ff - 16'd1;
   assign ack_load = (ack_timeout_ff == '0) ? 16'd1 : ack_timeout_ff;
   assign bit_next = bit_index_ff + 4'd1;

   always_comb begin
      phase_in           = phase_ff;
      stage_in           = stage_ff;
      bit_index_in       = bit_index_ff;
      shift_byte_in      = shift_byte_ff;
      bytes_left_in      = bytes_left_ff;
      delay_timer_in     = delay_timer_ff;
      ack_timer_in       = ack_timer_ff;
      held_device_in     = held_device_ff;
      held_register_in   = held_register_ff;
      held_write_byte_in = held_write_byte_ff;
      is_read_in         = is_read_ff;
      failed_in          = failed_ff;
      scl_in             = scl_ff;
      sda_drive_in       = sda_drive_ff;
      rd_data            = '0;
      rd_valid           = 1'b0;
      rd_last            = 1'b0;
      done               = 1'b0;
      status             = 1'b0;
      hold               = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (op == OP_WRITE || op == OP_READ) begin
            held_device_in     = f_dev;
            held_register_in   = f_reg;
            held_write_byte_in = f_wdata;
            bytes_left_in      = (f_count == '0) ? 8'd1 : f_count;
            is_read_in         = (op == OP_READ);
            failed_in          = 1'b0;
            stage_in           = STG_DEVICE;
            bit_index_in       = '0;
            shift_byte_in      = '0;
            delay_timer_in     = '0;
            ack_timer_in       = '0;
            phase_in           = PH_START_A;
         end
      end else if (op == OP_TICK) begin
         if (delay_timer_ff != '0) begin
            delay_timer_in = delay_timer_ff - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
         end else begin
            case (phase_ff)
               PH_START_A: begin
                  scl_in = 1'b1; sda_drive_in = 1'b1; hold = 1'b1;
                  phase_in = PH_START_B;
               end
               PH_START_B: begin
                  sda_drive_in = 1'b0; hold = 1'b1;
                  // read address after the repeated start
                  shift_byte_in = (stage_ff == STG_READ) ? held_device_ff + 8'd1
                                                         : held_device_ff;
                  bit_index_in  = '0;
                  phase_in      = PH_WR_SETUP;
               end
               PH_WR_SETUP: begin
                  scl_in = 1'b0; sda_drive_in = shift_byte_ff[7]; hold = 1'b1;
                  phase_in = PH_WR_HIGH;
               end
               PH_WR_HIGH: begin
                  scl_in = 1'b1; hold = 1'b1;
                  shift_byte_in = {shift_byte_ff[6:0], 1'b0};
                  bit_index_in  = bit_next;
                  phase_in      = (bit_next >= 4'd8) ? PH_ACK_REL : PH_WR_SETUP;
               end
               PH_ACK_REL: begin
                  scl_in = 1'b0; sda_drive_in = 1'b1; hold = 1'b1;
                  phase_in = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  scl_in = 1'b1; hold = 1'b1;
                  ack_timer_in = sat_timer(ack_load);
                  phase_in     = PH_ACK_POLL;
               end
               PH_ACK_POLL: begin
                  if (!f_sda) begin
                     scl_in = 1'b0;
                     case (stage_ff)
                        STG_DEVICE: begin
                           stage_in      = STG_REGISTER;
                           shift_byte_in = held_register_ff;
                           bit_index_in  = '0;
                           phase_in      = PH_WR_SETUP;
                        end
                        STG_REGISTER: begin
                           if (is_read_ff) begin
                              stage_in = STG_READ;
                              phase_in = PH_START_A;
                           end else begin
                              stage_in      = STG_DATA;
                              shift_byte_in = held_write_byte_ff;
                              bit_index_in  = '0;
                              phase_in      = PH_WR_SETUP;
                           end
                        end
                        STG_READ: begin
                           shift_byte_in = '0;
                           bit_index_in  = '0;
                           phase_in      = PH_RD_LOW;
                        end
                        default: begin
                           phase_in = PH_STOP_A;
                        end
                     endcase
                  end else begin
                     ack_timer_in = ack_timer_ff - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
                     if (ack_timer_ff == {{(TIMER_WIDTH-1){1'b0}}, 1'b1}) begin
                        failed_in = 1'b1;
                        phase_in  = PH_STOP_A;
                     end
                  end
               end
               PH_RD_LOW: begin
                  scl_in = 1'b0; sda_drive_in = 1'b1; hold = 1'b1;
                  phase_in = PH_RD_HIGH;
               end
               PH_RD_HIGH: begin
                  scl_in = 1'b1; hold = 1'b1;
                  shift_byte_in = {shift_byte_ff[6:0], f_sda};
                  bit_index_in  = bit_next;
                  if (bit_next >= 4'd8) begin
                     rd_data  = {shift_byte_ff[6:0], f_sda};
                     rd_valid = 1'b1;
                     rd_last  = (bytes_left_ff <= 8'd1);
                     phase_in = PH_MACK_SET;
                  end else begin
                     phase_in = PH_RD_LOW;
                  end
               end
               PH_MACK_SET: begin
                  // nack on the last byte of the burst
                  scl_in = 1'b0; sda_drive_in = (bytes_left_ff <= 8'd1);
                  phase_in = PH_MACK_HIGH;
               end
               PH_MACK_HIGH: begin
                  scl_in = 1'b1; hold = 1'b1;
                  phase_in = PH_MACK_LOW;
               end
               PH_MACK_LOW: begin
                  scl_in = 1'b0; hold = 1'b1;
                  if (bytes_left_ff > 8'd1) begin
                     bytes_left_in = bytes_left_ff - 8'd1;
                     shift_byte_in = '0;
                     bit_index_in  = '0;
                     phase_in      = PH_RD_LOW;
                  end else begin
                     phase_in = PH_STOP_A;
                  end
               end
               PH_STOP_A: begin
                  scl_in = 1'b0; sda_drive_in = 1'b0; hold = 1'b1;
                  phase_in = PH_STOP_B;
               end
               PH_STOP_B: begin
                  scl_in = 1'b1; sda_drive_in = 1'b1; hold = 1'b1;
                  phase_in = PH_FINISH;
               end
               default: begin
                  done      = 1'b1;
                  status    = failed_ff;
                  failed_in = 1'b0;
                  phase_in  = PH_IDLE;
               end
            endcase
            if (hold) begin
               delay_timer_in = sat_timer(half_m1);
            end
         end
      end

      rsp_data_in = {2'b00, status, done, rd_valid, rd_data,
                     (phase_in != PH_IDLE), sda_drive_in, scl_in};
      rsp_last_in = rd_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
            default:         half_period_ff <= half_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         stage_ff           <= STG_DEVICE;
         bit_index_ff       <= '0;
         shift_byte_ff      <= '0;
         bytes_left_ff      <= '0;
         delay_timer_ff     <= '0;
         ack_timer_ff       <= '0;
         held_device_ff     <= '0;
         held_register_ff   <= '0;
         held_write_byte_ff <= '0;
         is_read_ff         <= 1'b0;
         failed_ff          <= 1'b0;
         scl_ff             <= 1'b1;
         sda_drive_ff       <= 1'b1;
      end else if (accept) begin
         phase_ff           <= phase_in;
         stage_ff           <= stage_in;
         bit_index_ff       <= bit_index_in;
         shift_byte_ff      <= shift_byte_in;
         bytes_left_ff      <= bytes_left_in;
         delay_timer_ff     <= delay_timer_in;
         ack_timer_ff       <= ack_timer_in;
         held_device_ff     <= held_device_in;
         held_register_ff   <= held_register_in;
         held_write_byte_ff <= held_write_byte_in;
         is_read_ff         <= is_read_in;
         failed_ff          <= failed_in;
         scl_ff             <= scl_in;
         sda_drive_ff       <= sda_drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a read byte word leaves the sequencer waiting to drive the master ack
   a_rd_valid_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[11]) |-> (phase_ff == PH_MACK_SET))
      else $error("read byte reported outside the master ack step");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[12]) |-> (phase_ff == PH_IDLE && !rsp_data_ff[2]))
      else $error("done reported while still busy");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[13]) |-> rsp_data_ff[12])
      else $error("error status without done");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (delay_timer_ff == '0))
      else $error("delay timer running while idle");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index past a byte");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the i2c register access master: a word-level predictor
// of the SCL/SDA sequencer checks every response word. Depends on i2cmra_pkg and the
// i2c_master_register_access RTL.
module testbench;
   import i2cmra_pkg::*;

   typedef struct {
      opcode_type op;
      logic [7:0] target_addr;
      logic [7:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] read_count;
      logic       sda_in;
   } i2c_cmd_type;

   typedef struct {
      logic       scl;
      logic       sda_out;
      logic       busy;
      logic [7:0] rd_data;
      logic       rd_valid;
      logic       rd_last;
      logic       done;
      logic       status;
   } line_word_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [1:0]                req_tuser = OP_TICK;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_we = 1'b0;
   logic                      csr_addr = CSR_HALF_PERIOD;
   logic [CFG_WIDTH-1:0]      csr_wdata = '0;

   i2c_master_register_access dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   i2c_cmd_type   req_words_q[$];
   line_word_type line_expect_q[$];
   i2c_cmd_type   cur_word;
   int            errors = 0;

   // traffic knobs, changed only between phases
   int gap_max = 0;
   int stall_pct = 0;
   int hold_requests = 0;

   // predictor copy of the configuration and sequencer state
   logic [15:0] cfg_half = HALF_PERIOD_RESET;
   logic [15:0] cfg_ack = ACK_TIMEOUT_RESET;
   phase_type   ph = PH_IDLE;
   stage_type   stg = STG_DEVICE;
   logic [3:0]  bit_idx = '0;
   logic [7:0]  shreg = '0;
   logic [7:0]  bytes_left = '0;
   logic [15:0] delay_left = '0;
   logic [15:0] ack_left = '0;
   logic [7:0]  held_dev = '0;
   logic [7:0]  held_reg = '0;
   logic [7:0]  held_wr = '0;
   logic        rd_mode = 1'b0;
   logic        failed = 1'b0;
   logic        scl_q = 1'b1;
   logic        sda_q = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void load_byte(logic [7:0] b);
      shreg = b;
      bit_idx = '0;
      ph = PH_WR_SETUP;
   endfunction

   // one request word in, the line levels and flags it leaves behind out
   function automatic line_word_type advance_i2c(i2c_cmd_type w);
      line_word_type r;
      logic hold;
      r = '{default: '0};
      hold = 1'b0;
      if (ph == PH_IDLE) begin
         if (w.op == OP_WRITE || w.op == OP_READ) begin
            held_dev = w.target_addr;
            held_reg = w.reg_offset;
            held_wr = w.write_data;
            bytes_left = (w.read_count == 0) ? 8'd1 : w.read_count;
            rd_mode = (w.op == OP_READ);
            failed = 1'b0;
            stg = STG_DEVICE;
            bit_idx = '0;
            shreg = '0;
            delay_left = '0;
            ack_left = '0;
            ph = PH_START_A;
         end
      end else if (w.op == OP_TICK) begin
         if (delay_left != 0) begin
            delay_left--;
         end else begin
            case (ph)
               PH_START_A: begin
                  scl_q = 1'b1; sda_q = 1'b1; hold = 1'b1;
                  ph = PH_START_B;
               end
               PH_START_B: begin
                  sda_q = 1'b0; hold = 1'b1;
                  load_byte(stg == STG_READ ? 8'(held_dev + 8'd1) : held_dev);
               end
               PH_WR_SETUP: begin
                  scl_q = 1'b0; sda_q = shreg[7]; hold = 1'b1;
                  ph = PH_WR_HIGH;
               end
               PH_WR_HIGH: begin
                  scl_q = 1'b1; hold = 1'b1;
                  shreg = shreg << 1;
                  bit_idx++;
                  ph = (bit_idx >= 8) ? PH_ACK_REL : PH_WR_SETUP;
               end
               PH_ACK_REL: begin
                  scl_q = 1'b0; sda_q = 1'b1; hold = 1'b1;
                  ph = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  scl_q = 1'b1; hold = 1'b1;
                  ack_left = (cfg_ack == 0) ? 16'd1 : cfg_ack;
                  ph = PH_ACK_POLL;
               end
               PH_ACK_POLL: begin
                  if (!w.sda_in) begin
                     scl_q = 1'b0;
                     case (stg)
                        STG_DEVICE: begin
                           stg = STG_REGISTER;
                           load_byte(held_reg);
                        end
                        STG_REGISTER: begin
                           if (rd_mode) begin
                              stg = STG_READ;
                              ph = PH_START_A;
                           end else begin
                              stg = STG_DATA;
                              load_byte(held_wr);
                           end
                        end
                        STG_READ: begin
                           shreg = '0;
                           bit_idx = '0;
                           ph = PH_RD_LOW;
                        end
                        default: ph = PH_STOP_A;
                     endcase
                  end else begin
                     ack_left--;
                     if (ack_left == 0) begin
                        failed = 1'b1;
                        ph = PH_STOP_A;
                     end
                  end
               end
               PH_RD_LOW: begin
                  scl_q = 1'b0; sda_q = 1'b1; hold = 1'b1;
                  ph = PH_RD_HIGH;
               end
               PH_RD_HIGH: begin
                  scl_q = 1'b1; hold = 1'b1;
                  shreg = {shreg[6:0], w.sda_in};
                  bit_idx++;
                  if (bit_idx >= 8) begin
                     r.rd_data = shreg;
                     r.rd_valid = 1'b1;
                     r.rd_last = (bytes_left <= 1);
                     ph = PH_MACK_SET;
                  end else begin
                     ph = PH_RD_LOW;
                  end
               end
               PH_MACK_SET: begin
                  // nack on the last byte of the burst
                  scl_q = 1'b0; sda_q = (bytes_left <= 1);
                  ph = PH_MACK_HIGH;
               end
               PH_MACK_HIGH: begin
                  scl_q = 1'b1; hold = 1'b1;
                  ph = PH_MACK_LOW;
               end
               PH_MACK_LOW: begin
                  scl_q = 1'b0; hold = 1'b1;
                  if (bytes_left > 1) begin
                     bytes_left--;
                     shreg = '0;
                     bit_idx = '0;
                     ph = PH_RD_LOW;
                  end else begin
                     ph = PH_STOP_A;
                  end
               end
               PH_STOP_A: begin
                  scl_q = 1'b0; sda_q = 1'b0; hold = 1'b1;
                  ph = PH_STOP_B;
               end
               PH_STOP_B: begin
                  scl_q = 1'b1; sda_q = 1'b1; hold = 1'b1;
                  ph = PH_FINISH;
               end
               default: begin
                  r.done = 1'b1;
                  r.status = failed;
                  failed = 1'b0;
                  ph = PH_IDLE;
               end
            endcase
            if (hold)
               delay_left = (cfg_half == 0) ? 16'd0 : cfg_half - 16'd1;
         end
      end
      r.scl = scl_q;
      r.sda_out = sda_q;
      r.busy = (ph != PH_IDLE);
      return r;
   endfunction

   function automatic void push_word(opcode_type op, logic [7:0] dev, logic [7:0] ra,
                                     logic [7:0] wb, logic [7:0] cnt, logic sda);
      i2c_cmd_type w;
      w.op = op;
      w.target_addr = dev;
      w.reg_offset = ra;
      w.write_data = wb;
      w.read_count = cnt;
      w.sda_in = sda;
      req_words_q.push_back(w);
   endfunction

   // tick words; the operand fields are don't-care and carry random bits
   function automatic void push_ticks(int n, int sda_hi_pct);
      for (int i = 0; i < n; i++)
         push_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(99) < sda_hi_pct);
   endfunction

   // a command followed by ticks; to_end gives enough ticks to finish and idle a while
   function automatic int push_txn(opcode_type op, logic [7:0] dev, logic [7:0] ra,
                                   logic [7:0] wb, logic [7:0] cnt, int sda_hi_pct,
                                   bit to_end);
      int steps;
      int est;
      int n;
      steps = 65;
      if (op == OP_READ)
         steps += 24 + 19 * ((cnt == 0) ? 1 : int'(cnt));
      est = steps * ((cfg_half == 0) ? 1 : int'(cfg_half)) + 8;
      n = to_end ? est + 10 : $urandom_range(est / 2, est * 5 / 4);
      push_word(op, dev, ra, wb, cnt, $urandom_range(1));
      push_ticks(n, sda_hi_pct);
      return n;
   endfunction

   function automatic void random_traffic(int n_items, int sda_hi_pct);
      int made;
      opcode_type op;
      logic [7:0] cnt;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(99) < 8) begin
            // unused opcode, or a command that often lands mid-transaction
            op = $urandom_range(1) ? OP_NONE : opcode_type'($urandom_range(1, 2));
            push_word(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(1));
         end else begin
            op = $urandom_range(1) ? OP_READ : OP_WRITE;
            cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(3));
            made += 1 + push_txn(op, 8'($urandom), 8'($urandom), 8'($urandom), cnt,
                                 sda_hi_pct, 1'b0);
         end
      end
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin : drive
      i2c_cmd_type w;
      logic vld;
      if (!reset && (!req_tvalid || req_tready)) begin
         vld = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (req_words_q.size() != 0) begin
            w = req_words_q.pop_front();
            vld = 1'b1;
            req_tdata <= {7'b0, w.sda_in, w.read_count, w.write_data, w.reg_offset,
                          w.target_addr};
            req_tuser <= w.op;
            cur_word <= w;
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            end
         end
         req_tvalid <= vld;
      end
   end

   // receiver: short random stalls, plus a long hold-off on request
   int hold_left = 0;
   int stall_left = 0;
   int holds_done = 0;
   always @(posedge clock) begin : accept
      logic rdy;
      rdy = 1'b1;
      if (hold_left != 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = 400;
         rdy = 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rdy = 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = $urandom_range(7);
         rdy = 1'b0;
      end
      rsp_tready <= rdy;
   end

   task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      line_word_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (line_expect_q.size() == 0) begin
               $display("%0t: unexpected word, expected none actual %0h", $realtime,
                        rsp_tdata);
               errors++;
            end else begin
               want = line_expect_q.pop_front();
               check_field("scl", want.scl, rsp_tdata[0]);
               check_field("sda_out", want.sda_out, rsp_tdata[1]);
               check_field("busy", want.busy, rsp_tdata[2]);
               check_field("rd_data", want.rd_data, rsp_tdata[10:3]);
               check_field("rd_valid", want.rd_valid, rsp_tdata[11]);
               check_field("done", want.done, rsp_tdata[12]);
               check_field("status", want.status, rsp_tdata[13]);
               check_field("rd_last", want.rd_last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            line_expect_q.push_back(advance_i2c(cur_word));
      end
   end

   task automatic drain_all();
      while (req_words_q.size() != 0 || req_tvalid || line_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      if (idx == CSR_HALF_PERIOD)
         cfg_half = v;
      else
         cfg_ack = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender has paused until every word is back, so the block is quiet here
   task automatic start_phase(logic [15:0] half, logic [15:0] ack, int gaps, int stalls);
      drain_all();
      write_csr(CSR_HALF_PERIOD, half);
      write_csr(CSR_ACK_TIMEOUT, ack);
      gap_max = gaps;
      stall_pct = stalls;
   endtask

   initial begin : stimulus
      int unused;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: idle ticks, unused opcode, operand extremes, busy commands
      start_phase(16'd1, 16'd1000, 0, 0);
      push_ticks(2, 50);
      push_word(OP_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
      unused = push_txn(OP_WRITE, 8'h00, 8'h00, 8'hff, 8'h00, 0, 1'b1);
      unused = push_txn(OP_WRITE, 8'hff, 8'hff, 8'h00, 8'hff, 0, 1'b1);
      unused = push_txn(OP_READ, 8'hff, 8'h5a, 8'h00, 8'h00, 50, 1'b1);
      push_word(OP_READ, 8'h3c, 8'ha5, 8'h96, 8'h03, 1'b0);
      push_ticks(5, 50);
      push_word(OP_WRITE, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
      push_word(OP_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      push_word(OP_READ, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1);
      push_ticks(20, 50);

      // zero half period and zero timeout, mostly unacknowledged
      start_phase(16'd0, 16'd0, 6, 30);
      unused = push_txn(OP_WRITE, 8'ha0, 8'h0f, 8'h55, 8'h00, 100, 1'b1);
      random_traffic(20, 80);

      start_phase(16'd1, 16'd1, 3, 20);
      random_traffic(40, 40);

      // long receiver hold-off while words keep coming
      start_phase(16'd2, 16'd3, 2, 40);
      hold_requests++;
      random_traffic(60, 55);

      start_phase(16'd1, 16'd65535, 0, 0);
      random_traffic(40, 45);

      start_phase(16'd1, 16'd1000, 8, 60);
      random_traffic(40, 50);

      // burst read run to the end
      start_phase(16'd1, 16'd5, 0, 10);
      unused = push_txn(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'h03, 30, 1'b1);

      // longest step; the transaction is still mid-hold at the end
      start_phase(16'd65535, 16'd1000, 4, 30);
      push_word(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      push_ticks(12, 50);

      drain_all();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
